FILE: rtl/cdb_pkg.sv
// ----------------------------------------------------------------------------
// cdb_pkg
// Shared types and constants for the cube domain bounds and face counter.
// ----------------------------------------------------------------------------
`default_nettype none

package cdb_pkg;

    localparam int MAX_CUBES = 1024;
    localparam int IDX_W     = $clog2(MAX_CUBES);
    localparam int CNT_W     = IDX_W + 1;

    localparam int COORD_W = 31;
    localparam int EDGE_W  = 30;
    localparam int TOL_W   = 30;
    localparam int EXT_W   = 32;
    localparam int DIFF_W  = 34;

    localparam int N_AXES  = 3;
    localparam int N_TESTS = 2 * N_AXES;
    localparam int TAG_W   = 3;

    localparam int S_TDATA_W = 128;
    localparam int M_TDATA_W = 256;

    localparam logic signed [EXT_W-1:0] LOW_RESET  = {1'b0, {(EXT_W-1){1'b1}}};
    localparam logic signed [EXT_W-1:0] HIGH_RESET = {1'b1, {(EXT_W-1){1'b0}}};
    localparam logic [TOL_W-1:0]        TOL_RESET  = TOL_W'(1);

    localparam logic [TAG_W-1:0] LAST_TEST = TAG_W'(N_TESTS - 1);

    typedef struct packed {
        logic [EDGE_W-1:0]         edge_len;
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } cube_t;

    typedef struct packed {
        logic                      valid;
        logic [TAG_W-1:0]          tag;
        logic signed [COORD_W-1:0] coord;
        logic [EDGE_W-1:0]         edge_len;
        logic signed [EXT_W-1:0]   bound;
    } face_req_t;

    typedef struct packed {
        logic             valid;
        logic [TAG_W-1:0] tag;
        logic             hit;
    } face_rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_UPD  = 5'b00010,
        ST_RD   = 5'b00100,
        ST_TEST = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/cdb_cube_store.sv
// ----------------------------------------------------------------------------
// cdb_cube_store
// Cube memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module cdb_cube_store (
    input  wire logic                    aclk,
    input  wire logic                    we,
    input  wire logic [cdb_pkg::IDX_W-1:0] waddr,
    input  wire cdb_pkg::cube_t          wdata,
    input  wire logic                    re,
    input  wire logic [cdb_pkg::IDX_W-1:0] raddr,
    output cdb_pkg::cube_t               rdata
);

    cdb_pkg::cube_t mem [cdb_pkg::MAX_CUBES];
    cdb_pkg::cube_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/cdb_face_unit.sv
// ----------------------------------------------------------------------------
// cdb_face_unit
// Shared face test: |coord + edge - bound| < tolerance, with a registered difference.
// ----------------------------------------------------------------------------
`default_nettype none

module cdb_face_unit (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire cdb_pkg::face_req_t       req,
    input  wire logic [cdb_pkg::TOL_W-1:0] tolerance,
    output cdb_pkg::face_rsp_t            rsp
);

    logic signed [cdb_pkg::DIFF_W-1:0] diff_next;
    logic signed [cdb_pkg::DIFF_W-1:0] diff_reg;
    logic [cdb_pkg::TAG_W-1:0]         tag_reg;
    logic                              valid_reg;
    logic signed [cdb_pkg::DIFF_W-1:0] tol_pos;
    logic signed [cdb_pkg::DIFF_W-1:0] tol_neg;

    assign diff_next = cdb_pkg::DIFF_W'(req.coord)
                     + $signed({{(cdb_pkg::DIFF_W-cdb_pkg::EDGE_W){1'b0}}, req.edge_len})
                     - cdb_pkg::DIFF_W'(req.bound);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= req.valid;
        end
    end

    always_ff @(posedge aclk) begin
        diff_reg <= diff_next;
        tag_reg  <= req.tag;
    end

    assign tol_pos = $signed({{(cdb_pkg::DIFF_W-cdb_pkg::TOL_W){1'b0}}, tolerance});
    assign tol_neg = -tol_pos;

    assign rsp.valid = valid_reg;
    assign rsp.tag   = tag_reg;
    assign rsp.hit   = (diff_reg < tol_pos) && (diff_reg > tol_neg);

endmodule

`default_nettype wire

FILE: rtl/cube_domain_bounds_face_count_core.sv
// ----------------------------------------------------------------------------
// cube_domain_bounds_face_count_core
// Loads cubes, tracks their bounding box and counts cubes on each box face.
// ----------------------------------------------------------------------------
// Cubes arrive on the s_ channel, one request each; s_tlast closes the set.
// Each cube, while fewer than 1024 are held, is written to the store and
// widens the running box (accept, then store write and box update).
// s_tready is high only while the sequencer is idle.
// After the closing cube a count pass reads every stored cube back through
// the single read port and feeds one face test per cycle to the shared
// face unit: each stored cube takes a read and then six tests; the face
// unit then drains and the result is loaded into the output register.
// The result (box extents and six face counts) sits in an output register
// on the m_ channel; a stalled receiver holds the block in its final state
// until the previous result is taken, after which a new set starts.
// cfg_we writes face_tolerance; write it only while the block is idle.
// Reset (aresetn low, synchronous) empties the set, resets the box,
// sets face_tolerance to 1 and drops any pending result. There is no
// clearing pass: only entries written in the current set are read.
// ----------------------------------------------------------------------------
`default_nettype none

module cube_domain_bounds_face_count_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [29:0] cfg_wdata,      // face_tolerance
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // corner_x[30:0], corner_y[61:31], corner_z[92:62], edge_length[122:93]
    input  wire logic [127:0] s_tdata,
    input  wire logic        s_tlast,        // last_cube
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // box_x_low[30:0], box_x_high[62:31], box_y_low[93:63], box_y_high[125:94],
    // box_z_low[156:126], box_z_high[188:157], count_x_low_face[199:189],
    // count_x_high_face[210:200], count_y_low_face[221:211],
    // count_y_high_face[232:222], count_z_low_face[243:233],
    // count_z_high_face[254:244]
    output logic [255:0]     m_tdata
);

    localparam int CW = cdb_pkg::COORD_W;
    localparam int XW = cdb_pkg::EXT_W;
    localparam int NW = cdb_pkg::CNT_W;

    cdb_pkg::state_t state_reg, state_next;

    logic [cdb_pkg::TOL_W-1:0] tol_reg;
    cdb_pkg::cube_t            cur_reg;
    logic                      store_reg;
    logic                      last_reg;
    logic [NW-1:0]             loaded_reg;
    logic [NW-1:0]             idx_reg;
    logic [cdb_pkg::TAG_W-1:0] step_reg;
    logic signed [XW-1:0]      low_reg  [cdb_pkg::N_AXES];
    logic signed [XW-1:0]      high_reg [cdb_pkg::N_AXES];
    logic [NW-1:0]             cnt_reg  [cdb_pkg::N_TESTS];
    logic                      m_valid_reg;
    logic [255:0]              m_data_reg;

    logic                      s_fire;
    logic                      out_fire;
    logic                      idx_wrap;
    logic signed [CW-1:0]      axis_c [cdb_pkg::N_AXES];
    cdb_pkg::cube_t            rd_cube;
    cdb_pkg::face_req_t        req;
    cdb_pkg::face_rsp_t        rsp;
    logic [NW-1:0]             idx_inc;

    assign s_tready = (state_reg == cdb_pkg::ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign axis_c[0] = cur_reg.x;
    assign axis_c[1] = cur_reg.y;
    assign axis_c[2] = cur_reg.z;

    assign idx_inc  = idx_reg + NW'(1);
    assign idx_wrap = (idx_inc == loaded_reg);
    assign out_fire = (state_reg == cdb_pkg::ST_DONE) && !rsp.valid
                   && (!m_valid_reg || m_tready);

    cdb_cube_store u_store (
        .aclk  (aclk),
        .we    ((state_reg == cdb_pkg::ST_UPD) && store_reg),
        .waddr (loaded_reg[cdb_pkg::IDX_W-1:0]),
        .wdata (cur_reg),
        .re    (state_reg == cdb_pkg::ST_RD),
        .raddr (idx_reg[cdb_pkg::IDX_W-1:0]),
        .rdata (rd_cube)
    );

    always_comb begin
        req.valid    = (state_reg == cdb_pkg::ST_TEST);
        req.tag      = step_reg;
        req.edge_len = step_reg[0] ? rd_cube.edge_len : '0;
        case (step_reg[2:1])
            2'd0: begin
                req.coord = rd_cube.x;
                req.bound = step_reg[0] ? high_reg[0] : low_reg[0];
            end
            2'd1: begin
                req.coord = rd_cube.y;
                req.bound = step_reg[0] ? high_reg[1] : low_reg[1];
            end
            default: begin
                req.coord = rd_cube.z;
                req.bound = step_reg[0] ? high_reg[2] : low_reg[2];
            end
        endcase
    end

    cdb_face_unit u_face (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (req),
        .tolerance (tol_reg),
        .rsp       (rsp)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            cdb_pkg::ST_IDLE: begin
                if (s_fire) state_next = cdb_pkg::ST_UPD;
            end
            cdb_pkg::ST_UPD: begin
                if (!last_reg) begin
                    state_next = cdb_pkg::ST_IDLE;
                end else if (loaded_reg == '0 && !store_reg) begin
                    state_next = cdb_pkg::ST_DONE;
                end else begin
                    state_next = cdb_pkg::ST_RD;
                end
            end
            cdb_pkg::ST_RD: begin
                state_next = cdb_pkg::ST_TEST;
            end
            cdb_pkg::ST_TEST: begin
                if (step_reg == cdb_pkg::LAST_TEST) begin
                    state_next = idx_wrap ? cdb_pkg::ST_DONE : cdb_pkg::ST_RD;
                end
            end
            cdb_pkg::ST_DONE: begin
                if (out_fire) state_next = cdb_pkg::ST_IDLE;
            end
            default: state_next = cdb_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= cdb_pkg::ST_IDLE;
            tol_reg     <= cdb_pkg::TOL_RESET;
            loaded_reg  <= '0;
            m_valid_reg <= 1'b0;
            for (int a = 0; a < cdb_pkg::N_AXES; a++) begin
                low_reg[a]  <= cdb_pkg::LOW_RESET;
                high_reg[a] <= cdb_pkg::HIGH_RESET;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_we) tol_reg <= cfg_wdata;

            if (state_reg == cdb_pkg::ST_UPD && store_reg) begin
                loaded_reg <= loaded_reg + NW'(1);
                for (int a = 0; a < cdb_pkg::N_AXES; a++) begin
                    if (XW'(axis_c[a]) < low_reg[a]) low_reg[a] <= XW'(axis_c[a]);
                    if (XW'(axis_c[a]) + $signed({2'b00, cur_reg.edge_len}) > high_reg[a])
                        high_reg[a] <= XW'(axis_c[a])
                                     + $signed({2'b00, cur_reg.edge_len});
                end
            end

            if (out_fire) begin
                m_valid_reg <= 1'b1;
                loaded_reg  <= '0;
                for (int a = 0; a < cdb_pkg::N_AXES; a++) begin
                    low_reg[a]  <= cdb_pkg::LOW_RESET;
                    high_reg[a] <= cdb_pkg::HIGH_RESET;
                end
            end else if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            cur_reg.x        <= s_tdata[30:0];
            cur_reg.y        <= s_tdata[61:31];
            cur_reg.z        <= s_tdata[92:62];
            cur_reg.edge_len <= s_tdata[122:93];
            last_reg         <= s_tlast;
            store_reg        <= !loaded_reg[cdb_pkg::IDX_W];
        end

        case (state_reg)
            cdb_pkg::ST_UPD: begin
                idx_reg  <= '0;
                step_reg <= '0;
                for (int t = 0; t < cdb_pkg::N_TESTS; t++) cnt_reg[t] <= '0;
            end
            cdb_pkg::ST_TEST: begin
                if (step_reg == cdb_pkg::LAST_TEST) begin
                    step_reg <= '0;
                    idx_reg  <= idx_inc;
                end else begin
                    step_reg <= step_reg + cdb_pkg::TAG_W'(1);
                end
            end
            default: ;
        endcase

        if (rsp.valid && rsp.hit) begin
            cnt_reg[rsp.tag] <= cnt_reg[rsp.tag] + NW'(1);
        end

        if (out_fire) begin
            m_data_reg <= {1'b0,
                           cnt_reg[5], cnt_reg[4], cnt_reg[3],
                           cnt_reg[2], cnt_reg[1], cnt_reg[0],
                           high_reg[2], low_reg[2][CW-1:0],
                           high_reg[1], low_reg[1][CW-1:0],
                           high_reg[0], low_reg[0][CW-1:0]};
        end
    end

endmodule

`default_nettype wire
